// ===== sv/aes_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and AES helper functions (S-box, round, key step).
// Used by the cipher core and the port checker.
package aes_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW  = 3'd5;

  localparam logic [3:0] LAST_ROUND = 4'd14;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        first_block;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Four new schedule words from the previous eight (older half a, newer half b).
  function automatic logic [127:0] key_step(input logic [127:0] a, input logic [127:0] b,
                                            input logic rot, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = rot ? (sub_word({b[23:0], b[31:24]}) ^ {rcon, 24'h000000}) : sub_word(b[31:0]);
    n0 = a[127:96] ^ t;
    n1 = a[95:64] ^ n0;
    n2 = a[63:32] ^ n1;
    n3 = a[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // One cipher round. Byte n is bits [127-8n -: 8]; state is column-major.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[127 - 8*(r + 4*((c + r) & 3)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      if (last) begin
        o[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return o ^ k;
  endfunction

endpackage

// ===== sv/aes_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one item of payload type T.
// Instantiated with aes_pkg::plain_t and aes_pkg::cipher_t.
interface aes_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/aes256_cbc_encrypt.sv =====
`timescale 1ns / 1ps
// AES-256 CBC encryptor. Each plaintext item is XORed with the IV (first block of a
// message) or the previous ciphertext, then encrypted with FIPS-197 AES-256. Each item is
// first loaded as the chained block with the first round key added, then run through the
// rounds on a single shared round unit, one round per cycle unless the final round is
// held, with the key schedule rolled forward alongside it by one four-word step unit.
// plaintext.ready is low while an item is in the rounds, so a new item follows in the
// cycle after a result is registered. The final round waits while the output register
// still holds an untaken result. Key and IV writes are taken at any time; an item
// in the rounds keeps the key and chaining value it was loaded with, so a write affects
// the next item accepted. Depends on aes_pkg and aes_stream_if.
module aes256_cbc_encrypt (
  input  logic                           clk,
  input  logic                           rst,
  aes_stream_if.sink                     plaintext,
  aes_stream_if.source                   ciphertext,
  input  logic                           wr_en,
  input  logic [aes_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [aes_pkg::CFG_DATA_W-1:0] wr_data
);
  import aes_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [63:0]  key0, key1, key2, key3;
  logic [63:0]  iv_high, iv_low;
  logic [127:0] prev_cipher;

  logic         state;
  logic [3:0]   round;
  logic [127:0] blk;
  logic [127:0] key_cur;
  logic [127:0] key_nxt;
  logic [7:0]   rcon;
  logic         out_valid;
  cipher_t      out_data;

  logic         in_acc;
  logic         out_free;
  logic         last;
  logic         advance;
  logic [127:0] chain;
  logic [127:0] step_a, step_b;
  logic         step_rot;
  logic [7:0]   step_rcon;
  logic [127:0] step_out;
  logic [127:0] round_out;

  assign plaintext.ready  = (state == S_IDLE);
  assign in_acc           = plaintext.valid && plaintext.ready;
  assign ciphertext.valid = out_valid;
  assign ciphertext.data  = out_data;

  assign out_free = !out_valid || ciphertext.ready;
  assign last     = (round == LAST_ROUND);
  assign advance  = (state == S_RUN) && (!last || out_free);

  assign chain = plaintext.data.first_block ? {iv_high, iv_low} : prev_cipher;

  // Shared key step: seeded from the key registers at load, then from the rolling window.
  always_comb begin
    if (state == S_IDLE) begin
      step_a    = {key0, key1};
      step_b    = {key2, key3};
      step_rot  = 1'b1;
      step_rcon = RCON_FIRST;
    end else begin
      step_a    = key_cur;
      step_b    = key_nxt;
      step_rot  = !round[0];
      step_rcon = rcon;
    end
  end

  assign step_out  = key_step(step_a, step_b, step_rot, step_rcon);
  assign round_out = aes_round(blk, key_cur, last);

  always_ff @(posedge clk) begin
    if (rst) begin
      key0        <= '0;
      key1        <= '0;
      key2        <= '0;
      key3        <= '0;
      iv_high     <= '0;
      iv_low      <= '0;
      prev_cipher <= '0;
      state       <= S_IDLE;
      round       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_KEY0:    key0    <= wr_data;
          REG_KEY1:    key1    <= wr_data;
          REG_KEY2:    key2    <= wr_data;
          REG_KEY3:    key3    <= wr_data;
          REG_IV_HIGH: iv_high <= wr_data;
          REG_IV_LOW:  iv_low  <= wr_data;
          default: ;
        endcase
      end

      if (out_valid && ciphertext.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RUN;
            round <= 4'd1;
          end
        end
        S_RUN: begin
          if (advance) begin
            if (last) begin
              state       <= S_IDLE;
              out_valid   <= 1'b1;
              prev_cipher <= round_out;
            end else begin
              round <= round + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: cipher state, key window, round constant and output result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (in_acc) begin
        blk     <= {plaintext.data.plain_high, plaintext.data.plain_low} ^ chain ^
                   {key0, key1};
        key_cur <= {key2, key3};
        key_nxt <= step_out;
        rcon    <= xtime(RCON_FIRST);
      end
    end else if (advance) begin
      blk     <= round_out;
      key_cur <= key_nxt;
      key_nxt <= step_out;
      if (step_rot) begin
        rcon <= xtime(rcon);
      end
      if (last) begin
        out_data.cipher_high <= round_out[127:64];
        out_data.cipher_low  <= round_out[63:0];
      end
    end
  end

endmodule

// ===== sv/aes_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for aes256_cbc_encrypt, bound to the top level below.
// Depends on aes_pkg for the result item type.
module aes_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input aes_pkg::cipher_t out_data
);
  import aes_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input ready stayed high after an item was accepted");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result delivered with no item outstanding");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> pending <= 2'd1)
    else $error("item accepted while two results are outstanding");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc, 15))
    else $error("result appeared other than 15 cycles after its item");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

endmodule

bind aes256_cbc_encrypt aes_checker u_aes_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (plaintext.valid),
  .in_ready  (plaintext.ready),
  .out_valid (ciphertext.valid),
  .out_ready (ciphertext.ready),
  .out_data  (ciphertext.data)
);
